[rtl/axrot_pkg.sv]
// ----------------------------------------------------------------------------
// axrot_pkg
// Shared types, constants and the arctangent table for the axis rotation
// matrix generator.
// ----------------------------------------------------------------------------
package axrot_pkg;

	// Field widths of the input and result items.
	localparam int ANGLE_WIDTH     = 16;
	localparam int COEF_FRAC_BITS  = 14;
	localparam int OUT_W           = COEF_FRAC_BITS + 2;

	// CORDIC datapath: 32-bit words, 30 fraction bits for x and y,
	// z in units of 2^-32 turn.
	localparam int CW              = 32;
	localparam int CORDIC_STEPS    = 30;
	localparam int CORDIC_FRAC     = 30;
	localparam int STEPS_PER_STAGE = 2;
	localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;

	// Input register, CORDIC stages, rounding register, output register.
	localparam int LATENCY         = CORDIC_STAGES + 3;

	localparam logic signed [CW-1:0] CORDIC_GAIN_INV = 32'sd652032874;

	localparam logic signed [OUT_W-1:0] COEF_ONE  = OUT_W'(1 << COEF_FRAC_BITS);
	localparam logic signed [OUT_W-1:0] COEF_ZERO = '0;

	// Axis selector codes.
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef struct packed {
		logic [1:0]                    func;
		logic signed [ANGLE_WIDTH-1:0] angle;
	} request_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] m00;
		logic signed [OUT_W-1:0] m01;
		logic signed [OUT_W-1:0] m02;
		logic signed [OUT_W-1:0] m10;
		logic signed [OUT_W-1:0] m11;
		logic signed [OUT_W-1:0] m12;
		logic signed [OUT_W-1:0] m20;
		logic signed [OUT_W-1:0] m21;
		logic signed [OUT_W-1:0] m22;
	} result_t;

	// Control that travels down the pipeline beside the data.
	typedef struct packed {
		logic [1:0] func;
		logic       flip;
	} ctl_t;

	// atan(2^-step) in units of 2^-32 turn.
	function automatic logic signed [CW-1:0] atan_turn(input int step);
		case (step)
			0:  return 32'sd536870912;
			1:  return 32'sd316933406;
			2:  return 32'sd167458907;
			3:  return 32'sd85004756;
			4:  return 32'sd42667331;
			5:  return 32'sd21354465;
			6:  return 32'sd10679838;
			7:  return 32'sd5340245;
			8:  return 32'sd2670163;
			9:  return 32'sd1335087;
			10: return 32'sd667544;
			11: return 32'sd333772;
			12: return 32'sd166886;
			13: return 32'sd83443;
			14: return 32'sd41722;
			15: return 32'sd20861;
			16: return 32'sd10430;
			17: return 32'sd5215;
			18: return 32'sd2608;
			19: return 32'sd1304;
			20: return 32'sd652;
			21: return 32'sd326;
			22: return 32'sd163;
			23: return 32'sd81;
			24: return 32'sd41;
			25: return 32'sd20;
			26: return 32'sd10;
			27: return 32'sd5;
			28: return 32'sd3;
			29: return 32'sd1;
			default: return '0;
		endcase
	endfunction

endpackage

[rtl/axis_rotation_matrix.sv]
// ----------------------------------------------------------------------------
// axis_rotation_matrix
// Elementary 3-D rotation matrix about the x, y or z axis, entries in Q1.14.
// An accepted start passes the input register, the CORDIC stages, the
// rounding register and the output register before done rises.
// Throughput: one transfer per cycle; the 15-stage CORDIC, two micro-rotations
// per stage, is fully pipelined so busy stays low.
// Reset (arst_n low) clears every valid bit; results in flight are dropped.
// The receiver cannot stall, so each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module axis_rotation_matrix (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  axrot_pkg::request_t request,
	output logic                busy,
	output logic                done,
	output axrot_pkg::result_t  result
);
	import axrot_pkg::*;

	// Every cycle can take a new transfer: the pipeline never holds back.
	assign busy = 1'b0;

	logic                    cs_valid;
	ctl_t                    cs_ctl;
	logic signed [OUT_W-1:0] cs_cos;
	logic signed [OUT_W-1:0] cs_sin;

	// Sine and cosine of the angle, with the axis selector carried alongside.
	axrot_sincos u_sincos (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (start && !busy),
		.req_in   (request),
		.valid_out(cs_valid),
		.ctl_out  (cs_ctl),
		.cos_out  (cs_cos),
		.sin_out  (cs_sin)
	);

	// Place cosine and sine into the matrix for the selected axis. The y axis
	// keeps minus sine in row 0, column 2. The unused selector code gives the
	// identity matrix.
	result_t mat_c;

	always_comb begin
		mat_c = '{default: COEF_ZERO};
		case (cs_ctl.func)
			AXIS_X: begin
				mat_c.m00 = COEF_ONE;
				mat_c.m11 = cs_cos;
				mat_c.m12 = -cs_sin;
				mat_c.m21 = cs_sin;
				mat_c.m22 = cs_cos;
			end
			AXIS_Y: begin
				mat_c.m00 = cs_cos;
				mat_c.m02 = -cs_sin;
				mat_c.m11 = COEF_ONE;
				mat_c.m20 = cs_sin;
				mat_c.m22 = cs_cos;
			end
			AXIS_Z: begin
				mat_c.m00 = cs_cos;
				mat_c.m01 = -cs_sin;
				mat_c.m10 = cs_sin;
				mat_c.m11 = cs_cos;
				mat_c.m22 = COEF_ONE;
			end
			default: begin
				mat_c.m00 = COEF_ONE;
				mat_c.m11 = COEF_ONE;
				mat_c.m22 = COEF_ONE;
			end
		endcase
	end

	// Output register: the strobe is reset, the matrix is plain payload.
	logic    done_q;
	result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cs_valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= mat_c;
	end

	assign done   = done_q;
	assign result = result_q;

	// Every accepted transfer produces its result after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("result missing after accepted transfer");

	// No result appears without a transfer accepted at the matching time.
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching transfer");

	// The clamp keeps every cosine within plus or minus one; this checks entry m22.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.m22 <= COEF_ONE && result.m22 >= -COEF_ONE))
		else $error("coefficient out of range");

	// An x-axis rotation leaves the first row as the unit vector.
	a_axis_x: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(request.func, LATENCY) == AXIS_X) |->
		(result.m00 == COEF_ONE && result.m01 == COEF_ZERO && result.m02 == COEF_ZERO))
		else $error("x-axis matrix has wrong first row");

endmodule

[rtl/axrot_cordic_stage.sv]
// ----------------------------------------------------------------------------
// axrot_cordic_stage
// One register stage of the rotation-mode CORDIC, performing a fixed group of
// consecutive micro-rotations.
// ----------------------------------------------------------------------------
module axrot_cordic_stage #(
	parameter int FIRST_STEP = 0
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            valid_in,
	input  axrot_pkg::ctl_t                 ctl_in,
	input  logic signed [axrot_pkg::CW-1:0] x_in,
	input  logic signed [axrot_pkg::CW-1:0] y_in,
	input  logic signed [axrot_pkg::CW-1:0] z_in,
	output logic                            valid_s1,
	output axrot_pkg::ctl_t                 ctl_s1,
	output logic signed [axrot_pkg::CW-1:0] x_s1,
	output logic signed [axrot_pkg::CW-1:0] y_s1,
	output logic signed [axrot_pkg::CW-1:0] z_s1
);
	import axrot_pkg::*;

	logic signed [CW-1:0] x_c;
	logic signed [CW-1:0] y_c;
	logic signed [CW-1:0] z_c;

	always_comb begin
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;
		x_c = x_in;
		y_c = y_in;
		z_c = z_in;
		for (int k = 0; k < STEPS_PER_STAGE; k++) begin
			xs = x_c >>> (FIRST_STEP + k);
			ys = y_c >>> (FIRST_STEP + k);
			if (!z_c[CW-1]) begin
				x_c = x_c - ys;
				y_c = y_c + xs;
				z_c = z_c - atan_turn(FIRST_STEP + k);
			end else begin
				x_c = x_c + ys;
				y_c = y_c - xs;
				z_c = z_c + atan_turn(FIRST_STEP + k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1 <= ctl_in;
		x_s1   <= x_c;
		y_s1   <= y_c;
		z_s1   <= z_c;
	end

endmodule

[rtl/axrot_sincos.sv]
// ----------------------------------------------------------------------------
// axrot_sincos
// Pipelined sine and cosine: quadrant folding, a chain of CORDIC stages, then
// rounding and clamping to the coefficient format.
// ----------------------------------------------------------------------------
module axrot_sincos (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               valid_in,
	input  axrot_pkg::request_t                req_in,
	output logic                               valid_out,
	output axrot_pkg::ctl_t                    ctl_out,
	output logic signed [axrot_pkg::OUT_W-1:0] cos_out,
	output logic signed [axrot_pkg::OUT_W-1:0] sin_out
);
	import axrot_pkg::*;

	localparam int SH = CORDIC_FRAC - COEF_FRAC_BITS;
	localparam logic signed [CW:0] ROUND_ADD = (SH == 0) ? '0 : (CW+1)'(1 << (SH - 1));
	localparam logic signed [CW:0] ONE_W     = (CW+1)'(1 << COEF_FRAC_BITS);

	// Angle widened to 32 bits of a turn and folded into the right half plane.
	logic [CW-1:0] turn;
	logic          flip;
	logic [CW-1:0] folded;

	always_comb begin
		turn   = CW'($unsigned(req_in.angle)) << (CW - ANGLE_WIDTH);
		flip   = turn[CW-1] ^ turn[CW-2];
		folded = flip ? {~turn[CW-1], turn[CW-2:0]} : turn;
	end

	wire                  valid_w [CORDIC_STAGES+1];
	wire ctl_t            ctl_w   [CORDIC_STAGES+1];
	wire signed [CW-1:0]  x_w     [CORDIC_STAGES+1];
	wire signed [CW-1:0]  y_w     [CORDIC_STAGES+1];
	wire signed [CW-1:0]  z_w     [CORDIC_STAGES+1];

	// Input register: folded angle and control. The starting vector is fixed.
	logic                 valid_s0;
	ctl_t                 ctl_s0;
	logic signed [CW-1:0] z_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else begin
			valid_s0 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s0.func <= req_in.func;
		ctl_s0.flip <= flip;
		z_s0        <= $signed(folded);
	end

	assign valid_w[0] = valid_s0;
	assign ctl_w[0]   = ctl_s0;
	assign x_w[0]     = CORDIC_GAIN_INV;
	assign y_w[0]     = '0;
	assign z_w[0]     = z_s0;

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
		axrot_cordic_stage #(
			.FIRST_STEP(g * STEPS_PER_STAGE)
		) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_in(valid_w[g]),
			.ctl_in  (ctl_w[g]),
			.x_in    (x_w[g]),
			.y_in    (y_w[g]),
			.z_in    (z_w[g]),
			.valid_s1(valid_w[g+1]),
			.ctl_s1  (ctl_w[g+1]),
			.x_s1    (x_w[g+1]),
			.y_s1    (y_w[g+1]),
			.z_s1    (z_w[g+1])
		);
	end

	// Undo the fold, round half up and clamp to plus or minus one.
	function automatic logic signed [OUT_W-1:0] to_coef(input logic signed [CW-1:0] v,
		input logic neg);
		logic signed [CW:0] w;
		logic signed [CW:0] r;
		w = (CW+1)'(v);
		if (neg) begin
			w = -w;
		end
		r = (w + ROUND_ADD) >>> SH;
		if (r > ONE_W) begin
			r = ONE_W;
		end else if (r < -ONE_W) begin
			r = -ONE_W;
		end
		return r[OUT_W-1:0];
	endfunction

	logic                    valid_s1;
	ctl_t                    ctl_s1;
	logic signed [OUT_W-1:0] cos_s1;
	logic signed [OUT_W-1:0] sin_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_w[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1 <= ctl_w[CORDIC_STAGES];
		cos_s1 <= to_coef(x_w[CORDIC_STAGES], ctl_w[CORDIC_STAGES].flip);
		sin_s1 <= to_coef(y_w[CORDIC_STAGES], ctl_w[CORDIC_STAGES].flip);
	end

	assign valid_out = valid_s1;
	assign ctl_out   = ctl_s1;
	assign cos_out   = cos_s1;
	assign sin_out   = sin_s1;

endmodule

[dv/axis_rotation_matrix_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_rotation_matrix_test
// Self-checking testbench for the axis rotation matrix generator. Requests
// are sent as start transfers: directed angles and selectors, a full-rate
// stream, then random bursts with random gaps. Every accepted request is
// run through a bit-exact CORDIC predictor kept here. Every done strobe is
// compared entry by entry with the oldest matrix that is still pending.
// ----------------------------------------------------------------------------
module axis_rotation_matrix_test;
	import axrot_pkg::*;

	// The fourth selector code has no axis; the block answers with identity.
	localparam logic [1:0] AXIS_NONE = 2'd3;

	// Predictor CORDIC: 30 micro-rotations, x and y with 30 fraction bits,
	// z in units of 2^-32 turn, x preloaded with the inverse CORDIC gain.
	localparam int     ROT_STEPS = 30;
	localparam int     ROT_FRAC  = 30;
	localparam longint ROT_GAIN  = 64'sd652032874;

	// atan(2^-i) in units of 2^-32 turn.
	localparam longint ATAN_TURNS [ROT_STEPS] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1
	};

	localparam int RANDOM_ITEMS  = 1750;
	localparam int STREAM_ITEMS  = 200;
	localparam int REPORT_LIMIT  = 10;
	// Covers the block's latency with margin before deciding that nothing
	// else will come out.
	localparam int SETTLE_CYCLES = 24;
	localparam int DRAIN_LIMIT   = 2000;

	typedef logic signed [8:0][OUT_W-1:0] entries_t;

	logic     clk;
	logic     arst_n;
	logic     start;
	request_t request;
	logic     busy;
	logic     done;
	result_t  result;

	// Matrices predicted for accepted requests, oldest first.
	result_t  pending_matrices [$];
	int       mismatch_count = 0;

	result_t  want_matrix;
	entries_t want_entries;
	entries_t got_entries;
	string    entry_names [9] = '{"m00", "m01", "m02", "m10", "m11", "m12",
		"m20", "m21", "m22"};

	axis_rotation_matrix u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.done    (done),
		.result  (result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Rounds a 30-fraction-bit value half up to the coefficient format. The
	// result is then clamped to plus or minus one, because the gain
	// compensation can push a cosine slightly past 1.0.
	function automatic longint to_q14(input longint v);
		longint r;
		longint one;
		one = longint'(1) << COEF_FRAC_BITS;
		r = (v + (longint'(1) << (ROT_FRAC - COEF_FRAC_BITS - 1)))
			>>> (ROT_FRAC - COEF_FRAC_BITS);
		if (r > one)
			r = one;
		if (r < -one)
			r = -one;
		return r;
	endfunction

	// Expected matrix for one request.
	function automatic result_t rotation_matrix(input request_t req);
		logic [31:0] turn;
		logic        flip;
		longint      x, y, z, xs, ys, c, s, one;
		result_t     m;
		// The angle is widened to 32 bits of a turn. Angles in the second and
		// third quadrants are moved by half a turn and the results are
		// negated, so the CORDIC only sees angles within a quarter turn.
		turn = {req.angle, {(32 - ANGLE_WIDTH){1'b0}}};
		flip = turn[31] ^ turn[30];
		if (flip)
			turn = turn + 32'h8000_0000;
		z = longint'($signed(turn));
		x = ROT_GAIN;
		y = 0;
		for (int i = 0; i < ROT_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_TURNS[i];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_TURNS[i];
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = to_q14(x);
		s = to_q14(y);
		one = longint'(1) << COEF_FRAC_BITS;

		m = '0;
		case (req.func)
			AXIS_X: begin
				m.m00 = OUT_W'(one);
				m.m11 = OUT_W'(c);
				m.m12 = OUT_W'(-s);
				m.m21 = OUT_W'(s);
				m.m22 = OUT_W'(c);
			end
			// The y matrix puts minus sine in row 0, column 2.
			AXIS_Y: begin
				m.m00 = OUT_W'(c);
				m.m02 = OUT_W'(-s);
				m.m11 = OUT_W'(one);
				m.m20 = OUT_W'(s);
				m.m22 = OUT_W'(c);
			end
			AXIS_Z: begin
				m.m00 = OUT_W'(c);
				m.m01 = OUT_W'(-s);
				m.m10 = OUT_W'(s);
				m.m11 = OUT_W'(c);
				m.m22 = OUT_W'(one);
			end
			default: begin
				m.m00 = OUT_W'(one);
				m.m11 = OUT_W'(one);
				m.m22 = OUT_W'(one);
			end
		endcase
		return m;
	endfunction

	// A random request. Most use one of the three axes, and a few use the
	// unused selector. Five in eight angles are drawn over the full range.
	// The rest lie near zero, near a quarter turn, where the quadrant
	// fold switches, or near half a turn, where the angle wraps.
	function automatic request_t random_request();
		request_t req;
		int       pick;
		int       offset;
		pick = $urandom_range(0, 15);
		if (pick < 5)
			req.func = AXIS_X;
		else if (pick < 10)
			req.func = AXIS_Y;
		else if (pick < 15)
			req.func = AXIS_Z;
		else
			req.func = AXIS_NONE;
		offset = int'($urandom_range(0, 128)) - 64;
		case ($urandom_range(0, 7))
			5: req.angle = ANGLE_WIDTH'(offset);
			6: req.angle = ANGLE_WIDTH'(($urandom_range(0, 1) ? 16384 : -16384) + offset);
			7: req.angle = ANGLE_WIDTH'(-32768 + offset);
			default: req.angle = ANGLE_WIDTH'($urandom);
		endcase
		return req;
	endfunction

	// Raises start with one request and holds it until a transfer happens,
	// then records the matrix that the request should produce. This returns
	// right after the accepting edge, so a following call keeps start high
	// with no dead cycle.
	task automatic send_item(input request_t req);
		start   <= 1'b1;
		request <= req;
		do
			@(posedge clk);
		while (busy);
		pending_matrices.push_back(rotation_matrix(req));
	endtask

	// Leaves start low for the given number of cycles, at least one, and
	// puts noise on the request bus, which must be ignored.
	task automatic idle_for(input int cycles);
		start <= 1'b0;
		repeat (cycles) begin
			request <= random_request();
			@(posedge clk);
		end
	endtask

	// Holds start low until every pending matrix has come back.
	task automatic wait_all_results();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_matrices.size() != 0);
	endtask

	// Each axis at zero, at minus pi, at the top of the range, at plus and
	// minus a quarter turn, and at the smallest nonzero step. Then, for the z
	// axis, the angles on each side of the quadrant fold. All are sent back to back.
	task automatic test_special_angles();
		int         angles [6] = '{0, -32768, 32767, 16384, -16384, 1};
		logic [1:0] axes [3]   = '{AXIS_X, AXIS_Y, AXIS_Z};
		request_t   req;
		foreach (axes[a]) begin
			foreach (angles[k]) begin
				req.func  = axes[a];
				req.angle = ANGLE_WIDTH'(angles[k]);
				send_item(req);
			end
		end
		req.func  = AXIS_Z;
		req.angle = ANGLE_WIDTH'(16383);
		send_item(req);
		req.angle = ANGLE_WIDTH'(-16385);
		send_item(req);
		idle_for(3);
	endtask

	// The unused selector must give identity whatever the angle.
	task automatic test_unused_selector();
		request_t req;
		req.func  = AXIS_NONE;
		req.angle = ANGLE_WIDTH'(0);
		send_item(req);
		req.angle = ANGLE_WIDTH'(-32768);
		send_item(req);
		req.angle = ANGLE_WIDTH'($urandom);
		send_item(req);
		wait_all_results();
	endtask

	// A long stream at one transfer per cycle, then a full drain with the
	// pipeline empty before anything else goes in.
	task automatic test_full_rate_stream();
		repeat (STREAM_ITEMS)
			send_item(random_request());
		wait_all_results();
	endtask

	// Bursts of random length. After a burst there is either no gap, a
	// short random gap, or now and then a full drain.
	task automatic test_random_bursts(input int items);
		int left;
		int burst;
		left = items;
		while (left > 0) begin
			burst = $urandom_range(1, 40);
			if (burst > left)
				burst = left;
			repeat (burst)
				send_item(random_request());
			left -= burst;
			case ($urandom_range(0, 9))
				0, 1, 2: ;
				3: wait_all_results();
				default: idle_for($urandom_range(1, 12));
			endcase
		end
	endtask

	// Compares each result with the oldest pending matrix. Outputs are
	// sampled at the edge that ends the strobe cycle, so the block's own
	// updates at that edge are not yet visible.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_matrices.size() == 0) begin
				if (mismatch_count < REPORT_LIMIT)
					$display("%0t: result with no request pending: %h", $realtime, result);
				mismatch_count++;
			end else begin
				want_matrix  = pending_matrices.pop_front();
				want_entries = entries_t'(want_matrix);
				got_entries  = entries_t'(result);
				// m00 sits in the top bits of the struct, so entry k is slice 8-k.
				for (int k = 0; k < 9; k++) begin
					if (got_entries[8 - k] !== want_entries[8 - k]) begin
						if (mismatch_count < REPORT_LIMIT)
							$display("%0t: %s expected %0d, got %0d", $realtime,
								entry_names[k], want_entries[8 - k], got_entries[8 - k]);
						mismatch_count++;
					end
				end
			end
		end
	end

	initial begin : run_tests
		int waited;
		arst_n  = 1'b0;
		start   = 1'b0;
		request = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_special_angles();
		test_unused_selector();
		test_full_rate_stream();
		test_random_bursts(RANDOM_ITEMS - STREAM_ITEMS);

		// Let the pipeline empty. Then watch a while longer for any strobe
		// that no request asked for.
		start <= 1'b0;
		waited = 0;
		while (pending_matrices.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_matrices.size() != 0) begin
			$display("%0d requests never produced a result", pending_matrices.size());
			mismatch_count += pending_matrices.size();
		end

		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Safety net for a hung handshake. It ends the run as failed if it goes
	// on far longer than a full run needs.
	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

[files.f]
rtl/axrot_pkg.sv
rtl/axrot_cordic_stage.sv
rtl/axrot_sincos.sv
rtl/axis_rotation_matrix.sv
dv/axis_rotation_matrix_test.sv
